FILE: rtl/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg
// shared constants, payload types and controller/datapath interface types
// for the fixed partition fit allocator
// ----------------------------------------------------------------------------
package fpfa_pkg;

    // table geometry
    localparam int NUM_PARTITIONS = 16;
    localparam int IDX_W          = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

    // field widths
    localparam int SIZE_W  = 16;
    localparam int OWNER_W = 8;
    localparam int ENTRY_W = SIZE_W + OWNER_W;

    // action codes
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // fit policy codes
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // result status codes
    localparam logic [1:0] ST_LOADED    = 2'd0;
    localparam logic [1:0] ST_ALLOCATED = 2'd1;
    localparam logic [1:0] ST_NO_FIT    = 2'd2;
    localparam logic [1:0] ST_READ      = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         part_index;
        logic [SIZE_W-1:0]  part_size;
        logic [SIZE_W-1:0]  request_size;
        logic [OWNER_W-1:0] owner_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         granted_index;
        logic [SIZE_W-1:0]  entry_size;
        logic               entry_free;
        logic [OWNER_W-1:0] entry_owner;
    } out_item_t;

    // which result the datapath builds this cycle
    typedef enum logic [2:0] {
        RES_NONE,
        RES_LOADED,
        RES_NO_FIT,
        RES_READ,
        RES_ALLOC
    } res_kind_t;

    typedef struct packed {
        logic      capture;
        logic      load_wr;
        logic      rd_issue;
        logic      scan_start;
        logic      scan_step;
        res_kind_t res_kind;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       policy_ok;
        logic       scan_last;
        logic       found;
    } sts_t;

endpackage

FILE: rtl/fpfa_ram.sv
// ----------------------------------------------------------------------------
// fpfa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/fpfa_datapath.sv
// ----------------------------------------------------------------------------
// fpfa_datapath
// partition table, fit scan compare, result and output registers
// ----------------------------------------------------------------------------
module fpfa_datapath
    import fpfa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  in_item_t   s_data,
    output out_item_t  m_data,
    input  cmd_t       cmd,
    output sts_t       sts
);
    in_item_t            in_reg;
    out_item_t           res_reg, res_next;
    out_item_t           m_data_reg;
    logic [1:0]          policy_reg;

    logic [NUM_PARTITIONS-1:0] free_reg, free_next;
    logic [NUM_PARTITIONS-1:0] loaded_reg, loaded_next;

    logic [IDX_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                cmp_valid_reg;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;
    logic [SIZE_W-1:0]   pick_size_reg, pick_size_next;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;

    logic                idx_in_range;
    logic [IDX_W-1:0]    idx_addr;
    logic [SIZE_W-1:0]   cur_size;
    logic                fits;
    logic                take;
    logic [7:0]          pick_ext;

    assign idx_in_range = (32'(in_reg.part_index) < NUM_PARTITIONS);
    assign idx_addr     = IDX_W'(in_reg.part_index);
    assign pick_ext     = 8'(pick_reg);

    // table entry: size in upper bits, owner in lower bits
    fpfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_PARTITIONS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        ram_rd_en   = cmd.scan_step | cmd.rd_issue;
        ram_rd_addr = cmd.scan_step ? scan_cnt_reg : idx_addr;
        if (cmd.res_kind == RES_ALLOC) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pick_reg;
            ram_wr_data = {pick_size_reg, in_reg.owner_id};
        end else begin
            ram_wr_en   = cmd.load_wr & idx_in_range;
            ram_wr_addr = idx_addr;
            ram_wr_data = {in_reg.part_size, {OWNER_W{1'b0}}};
        end
    end

    // per-entry fit compare
    assign cur_size = ram_rd_data[ENTRY_W-1:OWNER_W];
    assign fits     = free_reg[cmp_idx_reg] && (cur_size >= in_reg.request_size);

    always_comb begin
        case (policy_reg)
            POL_FIRST: take = fits && !found_reg;
            POL_BEST:  take = fits && (!found_reg || (cur_size < pick_size_reg));
            POL_WORST: take = fits && (cur_size > pick_size_reg);
            default:   take = 1'b0;
        endcase
    end

    always_comb begin
        scan_cnt_next  = scan_cnt_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_size_next = pick_size_reg;
        if (cmd.scan_start) begin
            scan_cnt_next  = '0;
            found_next     = 1'b0;
            pick_next      = '0;
            pick_size_next = '0;
        end else begin
            if (cmd.scan_step) begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
            if (cmp_valid_reg && take) begin
                found_next     = 1'b1;
                pick_next      = cmp_idx_reg;
                pick_size_next = cur_size;
            end
        end
    end

    always_comb begin
        free_next   = free_reg;
        loaded_next = loaded_reg;
        if (cmd.load_wr && idx_in_range) begin
            free_next[idx_addr]   = 1'b1;
            loaded_next[idx_addr] = 1'b1;
        end
        if (cmd.res_kind == RES_ALLOC) begin
            free_next[pick_reg] = 1'b0;
        end
    end

    always_comb begin
        res_next = res_reg;
        case (cmd.res_kind)
            RES_LOADED: begin
                res_next        = '0;
                res_next.status = ST_LOADED;
            end
            RES_NO_FIT: begin
                res_next        = '0;
                res_next.status = ST_NO_FIT;
            end
            RES_READ: begin
                res_next        = '0;
                res_next.status = ST_READ;
                if (idx_in_range && loaded_reg[idx_addr]) begin
                    res_next.entry_size  = ram_rd_data[ENTRY_W-1:OWNER_W];
                    res_next.entry_free  = free_reg[idx_addr];
                    res_next.entry_owner = ram_rd_data[OWNER_W-1:0];
                end
            end
            RES_ALLOC: begin
                res_next               = '0;
                res_next.status        = ST_ALLOCATED;
                res_next.granted_index = pick_ext[3:0];
            end
            default: begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg    <= POL_FIRST;
            free_reg      <= '0;
            loaded_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                policy_reg <= cfg_wr_data;
            end
            free_reg      <= free_next;
            loaded_reg    <= loaded_next;
            cmp_valid_reg <= cmd.scan_step;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.scan_step) begin
            cmp_idx_reg <= scan_cnt_reg;
        end
        if (cmd.out_load) begin
            m_data_reg <= res_reg;
        end
        scan_cnt_reg  <= scan_cnt_next;
        pick_reg      <= pick_next;
        pick_size_reg <= pick_size_next;
        res_reg       <= res_next;
    end

    assign m_data = m_data_reg;

    assign sts.action    = in_reg.action;
    assign sts.policy_ok = (policy_reg == POL_FIRST) || (policy_reg == POL_BEST) ||
                           (policy_reg == POL_WORST);
    assign sts.scan_last = (scan_cnt_reg == IDX_W'(NUM_PARTITIONS - 1));
    assign sts.found     = found_reg;

endmodule

FILE: rtl/fpfa_ctrl.sv
// ----------------------------------------------------------------------------
// fpfa_ctrl
// sequencing state machine: decode, table scan, commit and output handoff
// ----------------------------------------------------------------------------
module fpfa_ctrl
    import fpfa_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd,
    input  sts_t sts
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_SCAN,
        S_SCAN_TAIL,
        S_COMMIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.res_kind = RES_NONE;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (sts.action)
                    ACT_LOAD: begin
                        cmd.load_wr  = 1'b1;
                        cmd.res_kind = RES_LOADED;
                        state_next   = S_DONE;
                    end
                    ACT_READ: begin
                        cmd.rd_issue = 1'b1;
                        state_next   = S_RD_WAIT;
                    end
                    ACT_ALLOC: begin
                        if (sts.policy_ok) begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end else begin
                            cmd.res_kind = RES_NO_FIT;
                            state_next   = S_DONE;
                        end
                    end
                    default: begin
                        cmd.res_kind = RES_NO_FIT;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_RD_WAIT: begin
                cmd.res_kind = RES_READ;
                state_next   = S_DONE;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_SCAN_TAIL;
                end
            end
            S_SCAN_TAIL: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.res_kind = sts.found ? RES_ALLOC : RES_NO_FIT;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/fixed_partition_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_unit
// fixed partition table with first, best and worst fit allocation
// ----------------------------------------------------------------------------
//
// channel   ports                              moves
// -------   --------------------------------   ------------------------------
// input     s_valid, s_ready, s_data           one load/allocate/read request
// output    m_valid, m_ready, m_data           one status/result transaction
// config    cfg_wr_en, cfg_wr_data             fit policy, no wait
//
// load and unknown actions go from decode straight to the result, read waits
// on the registered table read, and allocate scans every partition: one table
// ram read per partition through the single read port sets the scan length
// synchronous active-low reset clears the policy, the free and loaded marks
// and the handshake state; the table ram itself is not cleared
// a finished result sits in the output register while the next transaction
// is accepted; m_ready low only stalls the block at its final handoff
//
module fixed_partition_fit_allocator_unit
    import fpfa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // policy register
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    // request channel
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);
    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: decode, scan pacing, commit, output handoff
    fpfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath: partition table ram, free marks, fit compare, result regs
    fpfa_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_data      (m_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

FILE: dv/fixed_partition_fit_allocator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_unit_tb
// checks the partition table allocator under first, best, worst fit and the
// unused policy code; a local table model predicts each result, a directed
// pass hits the corner cases and random phases with idling and back-pressure
// follow
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_unit_tb;
    import fpfa_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] POL_UNUSED = 2'd3;

    localparam int DRAIN_CYCLES = NUM_PARTITIONS + 8;
    localparam int LONG_STALL   = 400;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = 2'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;

    // local copy of the partition table and the policy register
    logic [SIZE_W-1:0]  tbl_size  [NUM_PARTITIONS];
    logic               tbl_free  [NUM_PARTITIONS];
    logic [OWNER_W-1:0] tbl_owner [NUM_PARTITIONS];
    logic [1:0]         policy_now = POL_FIRST;

    // results predicted at accept time, oldest first
    out_item_t pending_results [$];

    int  errors = 0;
    int  requests_sent = 0;
    int  results_seen = 0;
    int  grants = 0;
    int  no_fits = 0;
    bit  steady_mode = 1'b0;     // no random idling on either side
    bit  long_stall_req = 1'b0;  // ask the receiver for one long hold-off
    bit  long_stall_taken = 1'b0;
    int  stall_left = 0;

    fixed_partition_fit_allocator_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // generous run limit, well above the slowest legal run
    initial begin
        #1_000_000;
        $display("timeout at %0t with %0d results pending", $time, pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // table model: applies one request, returns the result it should produce
    // ------------------------------------------------------------------------
    function automatic out_item_t serve_request(input in_item_t req);
        out_item_t         res;
        logic              found;
        int                pick;
        logic [SIZE_W-1:0] pick_sz;
        res     = '0;
        found   = 1'b0;
        pick    = 0;
        pick_sz = '0;
        case (req.action)
            ACT_LOAD: begin
                tbl_size[req.part_index]  = req.part_size;
                tbl_free[req.part_index]  = 1'b1;
                tbl_owner[req.part_index] = '0;
                res.status = ST_LOADED;
            end
            ACT_ALLOC: begin
                for (int i = 0; i < NUM_PARTITIONS; i++) begin
                    // only free partitions big enough are candidates
                    if (tbl_free[i] && tbl_size[i] >= req.request_size) begin
                        case (policy_now)
                            POL_FIRST: begin
                                if (!found) begin
                                    pick  = i;
                                    found = 1'b1;
                                end
                            end
                            POL_BEST: begin
                                if (!found || tbl_size[i] < pick_sz) begin
                                    pick    = i;
                                    pick_sz = tbl_size[i];
                                    found   = 1'b1;
                                end
                            end
                            POL_WORST: begin
                                // strict compare against a zero start: a
                                // zero-size partition is never taken
                                if (tbl_size[i] > pick_sz) begin
                                    pick    = i;
                                    pick_sz = tbl_size[i];
                                    found   = 1'b1;
                                end
                            end
                            default: ;  // unused policy never serves
                        endcase
                    end
                end
                if (found) begin
                    tbl_free[pick]    = 1'b0;
                    tbl_owner[pick]   = req.owner_id;
                    res.status        = ST_ALLOCATED;
                    res.granted_index = 4'(pick);
                    grants++;
                end else begin
                    res.status = ST_NO_FIT;
                    no_fits++;
                end
            end
            ACT_READ: begin
                res.status      = ST_READ;
                res.entry_size  = tbl_size[req.part_index];
                res.entry_free  = tbl_free[req.part_index];
                res.entry_owner = tbl_owner[req.part_index];
            end
            default: res.status = ST_NO_FIT;  // unused action, no effect
        endcase
        return res;
    endfunction

    function automatic in_item_t build_request(input logic [1:0] act, input int idx,
                                               input int psize, input int rsize,
                                               input int owner);
        in_item_t req;
        req.action       = act;
        req.part_index   = 4'(idx);
        req.part_size    = SIZE_W'(psize);
        req.request_size = SIZE_W'(rsize);
        req.owner_id     = OWNER_W'(owner);
        return req;
    endfunction

    // sizes lean toward a few small values, exact matches and near misses
    function automatic logic [SIZE_W-1:0] pick_size();
        int                r;
        logic [SIZE_W-1:0] base;
        r = $urandom_range(0, 99);
        if (r < 6)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        if (r < 40)
            return SIZE_W'($urandom_range(0, 7) * 16);
        if (r < 68)
            return SIZE_W'($urandom);
        base = tbl_size[$urandom_range(0, NUM_PARTITIONS - 1)];
        return base + SIZE_W'($urandom_range(0, 2)) - SIZE_W'(1);
    endfunction

    function automatic in_item_t random_request();
        in_item_t req;
        int       r;
        r = $urandom_range(0, 99);
        req.action       = (r < 35) ? ACT_LOAD : (r < 75) ? ACT_ALLOC :
                           (r < 95) ? ACT_READ : ACT_UNUSED;
        req.part_index   = 4'($urandom_range(0, NUM_PARTITIONS - 1));
        req.part_size    = pick_size();
        req.request_size = pick_size();
        req.owner_id     = OWNER_W'($urandom_range(0, 255));
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // sender: called at a rising edge, returns at the edge of acceptance with
    // s_valid still high so back-to-back transactions need no toggle
    // ------------------------------------------------------------------------
    task automatic send_request(input in_item_t req);
        if (!steady_mode && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(serve_request(req));
        requests_sent++;
    endtask

    // let every outstanding transaction come back, then a margin
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_policy(input logic [1:0] pol);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pol;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        policy_now = pol;
    endtask

    // ------------------------------------------------------------------------
    // receiver: checks each result transaction and drives m_ready
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_side
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, m_data);
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                check_field("status", 16'(want.status), 16'(m_data.status));
                check_field("granted_index", 16'(want.granted_index),
                            16'(m_data.granted_index));
                check_field("entry_size", want.entry_size, m_data.entry_size);
                check_field("entry_free", 16'(want.entry_free), 16'(m_data.entry_free));
                check_field("entry_owner", 16'(want.entry_owner), 16'(m_data.entry_owner));
            end
        end
        // one long hold-off on request, otherwise single random idle cycles
        if (long_stall_req && !long_stall_taken) begin
            long_stall_taken = 1'b1;
            stall_left       = LONG_STALL;
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (!steady_mode && $urandom_range(0, 99) < 7) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset policy is first fit; empty table, extremes of size and owner
    task automatic test_first_fit_basics();
        send_request(build_request(ACT_READ, 0, 0, 0, 0));
        send_request(build_request(ACT_READ, 15, 0, 0, 0));
        send_request(build_request(ACT_ALLOC, 0, 0, 1, 1));        // nothing loaded yet
        send_request(build_request(ACT_UNUSED, 15, 'hffff, 'hffff, 'hff));
        send_request(build_request(ACT_LOAD, 0, 0, 0, 0));
        send_request(build_request(ACT_LOAD, 15, 'hffff, 0, 0));
        send_request(build_request(ACT_LOAD, 7, 100, 0, 0));
        send_request(build_request(ACT_ALLOC, 0, 0, 0, 'hff));     // zero-size fits zero
        send_request(build_request(ACT_ALLOC, 0, 0, 'hffff, 0));   // only the max fits
        send_request(build_request(ACT_READ, 15, 0, 0, 0));
        send_request(build_request(ACT_READ, 0, 0, 0, 0));
    endtask

    // tie on size goes to the lower index; reload clears the owner
    task automatic test_best_fit_ties();
        write_policy(POL_BEST);
        send_request(build_request(ACT_LOAD, 0, 0, 0, 0));
        send_request(build_request(ACT_READ, 0, 0, 0, 0));
        send_request(build_request(ACT_LOAD, 15, 50, 0, 0));
        send_request(build_request(ACT_LOAD, 3, 50, 0, 0));
        send_request(build_request(ACT_LOAD, 5, 40, 0, 0));
        send_request(build_request(ACT_ALLOC, 0, 0, 45, 1));
        send_request(build_request(ACT_ALLOC, 0, 0, 0, 2));
    endtask

    // worst fit walks down by size and refuses the zero-size partition
    task automatic test_worst_fit_order();
        write_policy(POL_WORST);
        send_request(build_request(ACT_LOAD, 0, 0, 0, 0));
        send_request(build_request(ACT_ALLOC, 0, 0, 0, 3));
        send_request(build_request(ACT_ALLOC, 0, 0, 0, 4));
        send_request(build_request(ACT_ALLOC, 0, 0, 0, 5));
        send_request(build_request(ACT_ALLOC, 0, 0, 0, 6));
    endtask

    // unused policy code never grants, the partition stays free
    task automatic test_unused_policy();
        write_policy(POL_UNUSED);
        send_request(build_request(ACT_LOAD, 1, 10, 0, 0));
        send_request(build_request(ACT_ALLOC, 0, 0, 0, 7));
        send_request(build_request(ACT_READ, 1, 0, 0, 0));
    endtask

    // receiver holds off while the sender keeps offering, block fills up
    task automatic test_result_backpressure();
        write_policy(POL_BEST);
        steady_mode    = 1'b1;
        long_stall_req = 1'b1;
        repeat (60) send_request(random_request());
        steady_mode = 1'b0;
    endtask

    // policy phases with random traffic, one phase without any idling
    task automatic test_random_traffic(input int phases, input int per_phase);
        logic [1:0] pol;
        for (int p = 0; p < phases; p++) begin
            pol = (p % 7 == 3) ? POL_UNUSED : 2'(p % 3);
            write_policy(pol);
            steady_mode = (p == 5);
            repeat (per_phase) send_request(random_request());
        end
        steady_mode = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // model table matches the post-reset state
        for (int i = 0; i < NUM_PARTITIONS; i++) begin
            tbl_size[i]  = '0;
            tbl_free[i]  = 1'b0;
            tbl_owner[i] = '0;
        end

        test_first_fit_basics();
        test_best_fit_ties();
        test_worst_fit_order();
        test_unused_policy();
        test_result_backpressure();
        test_random_traffic(13, 100);

        drain_results();
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end
        $display("sent %0d requests over first, best, worst fit and the unused policy code",
                 requests_sent);
        $display("checked %0d results: %0d grants, %0d refusals", results_seen, grants,
                 no_fits);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
